// ===== rtl/grpe_pkg.sv =====
// Shared types, constants and codes for the radial Gaussian potential evaluator.
`timescale 1ns / 1ps
package grpe_pkg;

  localparam int MAX_PRIMS = 32;
  localparam int IDX_W     = $clog2(MAX_PRIMS);
  localparam int CNT_W     = $clog2(MAX_PRIMS + 1);

  // Table entry: exponent, coefficient, radial power, angular momentum
  localparam int ENT_W = 32 + 32 + 3 + 3;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
  localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
  localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;
  localparam logic [47:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MIN  = 48'h8000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_SQR, S_R2, S_FETCH, S_CHK, S_X, S_TMUL, S_TDIV, S_TREC,
    S_SQ, S_SQW, S_MAG, S_V, S_POW, S_POWH, S_POWW, S_ACC, S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

// ===== rtl/grpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module grpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/grpe_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module grpe_mul (
  input  logic               clk,
  input  grpe_pkg::mul_req_t req,
  output logic [63:0]        prod
);

  import grpe_pkg::*;

  // register the product every cycle
  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule

// ===== rtl/gaussian_radial_potential_eval_top.sv =====
// Top level: command port, primitive table, sequencer and datapath around one multiplier.
`timescale 1ns / 1ps
// A clear, load or unused command is accepted while idle and its result strobes on
// done in the next cycle. An evaluate squares the radius and walks every stored
// primitive through the one shared multiplier: one of another channel is skipped, a
// matching one takes fetch and range check, 5 series terms, 10 squarings, coefficient
// scaling and accumulate (no series or squarings when the exponential underflows),
// plus a scaling by the radius per radial power; done strobes when the sum is finished.
// busy stays high throughout. done is a single cycle strobe and cannot be held off;
// status 1 flags a load into a full table and status 2 a saturated sum.
module gaussian_radial_potential_eval_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [31:0]        exponent_in,
  input  logic signed [31:0] coef_in,
  input  logic [2:0]         power_in,
  input  logic [2:0]         prim_l_in,
  input  logic [31:0]        radius,
  input  logic [2:0]         query_l,
  output logic               done,
  output logic signed [47:0] potential,
  output logic [1:0]         status
);

  import grpe_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [31:0]      r;
  logic [2:0]       l;
  logic [35:0]      r2;
  logic [31:0]      coef;
  logic [2:0]       pw;
  logic [25:0]      y;
  logic [31:0]      t;
  logic [31:0]      s;
  logic [2:0]       k;
  logic [3:0]       j;
  logic [48:0]      v;
  logic [35:0]      lo;
  logic signed [54:0] acc;

  mul_req_t    mreq;
  logic [63:0] p;

  logic             accept;
  logic             full;
  logic             we;
  logic [ENT_W-1:0] rdata;
  logic [31:0]      e_a, e_c;
  logic [2:0]       e_pw, e_l;
  logic             match;
  logic             exp_zero;
  logic [31:0]      tq, t_new;
  logic [31:0]      mag;
  logic [53:0]      pow_sum;
  logic             in_range;

  assign accept = start && !busy;
  assign full   = (count == CNT_W'(MAX_PRIMS));
  assign we     = accept && action == ACT_LOAD && !full;
  assign {e_a, e_c, e_pw, e_l} = rdata;
  assign match  = (e_l == l);

  grpe_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PRIMS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({exponent_in, coef_in, power_in, prim_l_in}),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  grpe_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (p)
  );

  // datapath helpers
  assign exp_zero = ((r2[35:32] != 4'd0) && (e_a != 32'd0)) || (p[63:57] != 7'd0);
  assign tq       = p[62:31];
  assign mag      = coef[31] ? (~coef + 32'd1) : coef;
  assign pow_sum  = {p[48:0], 4'b0} + {18'd0, lo};
  assign in_range = (acc[54:47] == {8{acc[47]}});

  always_comb begin
    unique case (state)
      S_TREC:  t_new = (k == 3'd3) ? {1'b0, p[63:33]} : {2'b0, p[63:34]};
      default: t_new = (k == 3'd1) ? tq : (k == 3'd2) ? {1'b0, tq[31:1]} : {2'b0, tq[31:2]};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && action == ACT_EVAL) state_next = S_SQR;
      S_SQR:   state_next = S_R2;
      S_R2:    state_next = S_FETCH;
      S_FETCH: state_next = (idx == count) ? S_FIN : S_CHK;
      S_CHK:   state_next = match ? S_X : S_FETCH;
      S_X:     state_next = exp_zero ? S_MAG : S_TMUL;
      S_TMUL:  state_next = S_TDIV;
      S_TDIV: begin
        if (k == 3'd3 || k == 3'd5) state_next = S_TREC;
        else                        state_next = S_TMUL;
      end
      S_TREC:  state_next = (k == 3'd5) ? S_SQ : S_TMUL;
      S_SQ:    state_next = S_SQW;
      S_SQW:   state_next = (j == 4'd9) ? S_MAG : S_SQ;
      S_MAG:   state_next = S_V;
      S_V:     state_next = S_POW;
      S_POW:   state_next = (pw == 3'd0) ? S_ACC : S_POWH;
      S_POWH:  state_next = S_POWW;
      S_POWW:  state_next = S_POW;
      S_ACC:   state_next = S_FETCH;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: busy flag and multiplier operands
  always_comb begin
    busy   = (state != S_IDLE);
    mreq.a = 32'd0;
    mreq.b = 32'd0;
    unique case (state)
      S_SQR:  begin mreq.a = r;               mreq.b = r; end
      S_CHK:  begin mreq.a = e_a;             mreq.b = r2[31:0]; end
      S_TMUL: begin mreq.a = t;               mreq.b = {6'd0, y}; end
      S_TDIV: begin mreq.a = tq;              mreq.b = (k == 3'd3) ? RECIP3 : RECIP5; end
      S_SQ:   begin mreq.a = s;               mreq.b = s; end
      S_MAG:  begin mreq.a = mag;             mreq.b = s; end
      S_POW:  begin mreq.a = v[31:0];         mreq.b = r; end
      S_POWH: begin mreq.a = {15'd0, v[48:32]}; mreq.b = r; end
      default: begin mreq.a = 32'd0;          mreq.b = 32'd0; end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_IDLE && accept) begin
        if (action == ACT_CLEAR) count <= '0;
        if (we)                  count <= count + CNT_W'(1);
        if (action != ACT_EVAL)  done  <= 1'b1;
      end
      if (state == S_FIN) done <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        r         <= radius;
        l         <= query_l;
        acc       <= '0;
        potential <= '0;
        status    <= (action == ACT_LOAD && full) ? STAT_FULL : STAT_OK;
      end
      S_R2: begin
        r2  <= p[63:28];
        idx <= '0;
      end
      S_CHK: begin
        coef <= e_c;
        pw   <= e_pw;
        if (!match) idx <= idx + CNT_W'(1);
      end
      S_X: begin
        y <= p[56:31];
        t <= ONE_Q31;
        s <= exp_zero ? 32'd0 : ONE_Q31;
        k <= 3'd1;
      end
      S_TDIV, S_TREC: begin
        if (state == S_TREC || !(k == 3'd3 || k == 3'd5)) begin
          t <= t_new;
          s <= k[0] ? s - t_new : s + t_new;
          k <= k + 3'd1;
          j <= 4'd0;
        end
      end
      S_SQW: begin
        s <= p[62:31];
        j <= j + 4'd1;
      end
      S_V: v <= {8'd0, p[63:23]};
      S_POWH: lo <= p[63:28];
      S_POWW: begin
        v  <= (pow_sum > {5'd0, TERM_CAP}) ? TERM_CAP : pow_sum[48:0];
        pw <= pw - 3'd1;
      end
      S_ACC: begin
        acc <= coef[31] ? acc - $signed({6'd0, v}) : acc + $signed({6'd0, v});
        idx <= idx + CNT_W'(1);
      end
      S_FIN: begin
        if (in_range) begin
          potential <= acc[47:0];
          status    <= STAT_OK;
        end else begin
          potential <= acc[54] ? NEG_MIN : POS_MAX;
          status    <= STAT_SAT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/grpe_checker.sv =====
// Port-level checker for the evaluator, bound to the top level.
`timescale 1ns / 1ps
module grpe_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         action,
  input logic               done,
  input logic signed [47:0] potential,
  input logic [1:0]         status
);

  import grpe_pkg::*;

  // a non-evaluate transfer answers on the next cycle
  a_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action != ACT_EVAL |=> done)
    else $error("missing result after clear or load");

  // an evaluate transfer makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_EVAL |=> busy)
    else $error("evaluate did not start");

  // a saturated result sits on a bound
  a_sat: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_SAT |-> (potential == POS_MAX || potential == NEG_MIN))
    else $error("saturated result not at a bound");

  // a full-table load carries a zero potential
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_FULL |-> potential == 48'sd0)
    else $error("full-table status with non-zero potential");

endmodule

bind gaussian_radial_potential_eval_top grpe_checker u_grpe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .action    (action),
  .done      (done),
  .potential (potential),
  .status    (status)
);

// ===== dv/tb_gaussian_radial_potential_eval_top.sv =====
// Self-checking testbench for the radial Gaussian potential evaluator.
`timescale 1ns / 1ps
module tb_gaussian_radial_potential_eval_top;
  import grpe_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int  TARGET_CMDS = 600;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam bit [63:0] EXP_CUTOFF = 64'd32 << 28;
  localparam bit [63:0] MAG_CAP    = 64'd1 << 48;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] expo;
    logic [31:0] coef;
    logic [2:0]  pow;
    logic [2:0]  lp;
    logic [31:0] rad;
    logic [2:0]  ql;
    bit          fixed;
    logic [47:0] fpot;
    logic [1:0]  fstat;
  } cmd_t;

  typedef struct {
    logic [47:0] pot;
    logic [1:0]  stat;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = ACT_CLEAR;
  logic [31:0] exponent_in = '0;
  logic signed [31:0] coef_in = '0;
  logic [2:0] power_in = '0;
  logic [2:0] prim_l_in = '0;
  logic [31:0] radius = '0;
  logic [2:0] query_l = '0;
  logic busy, done;
  logic signed [47:0] potential;
  logic [1:0] status;

  cmd_t     cmds[$];
  outcome_t pending[$];
  int       errors = 0;
  int       n_eval = 0, n_sat = 0, n_full = 0;
  longint   cycles = 0;
  int       pause_at;

  // shadow copy of the primitive table
  logic [31:0] sh_expo[MAX_PRIMS];
  logic [31:0] sh_coef[MAX_PRIMS];
  logic [2:0]  sh_pow[MAX_PRIMS];
  logic [2:0]  sh_l[MAX_PRIMS];
  int          sh_count = 0;

  gaussian_radial_potential_eval_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .exponent_in(exponent_in), .coef_in(coef_in), .power_in(power_in),
    .prim_l_in(prim_l_in), .radius(radius), .query_l(query_l), .done(done),
    .potential(potential), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(a*b / 2^28) without losing the top bits of a
  function automatic bit [63:0] scale_q28(bit [63:0] a, bit [63:0] b);
    bit [63:0] ah, al;
    ah = a >> 32;
    al = a & 64'hFFFF_FFFF;
    return ((ah * b) << 4) + ((al * b) >> 28);
  endfunction

  // exp(-x), x in Q.28, result in Q1.31
  function automatic bit [63:0] gauss_exp(bit [63:0] x);
    bit [63:0] y, t, s;
    if (x >= EXP_CUTOFF) return 64'd0;
    y = x >> 7;
    t = 64'd1 << 31;
    s = 64'd1 << 31;
    for (int k = 1; k <= 5; k++) begin
      t = ((t * y) >> 31) / k;
      if (k % 2) s = s - t;
      else s = s + t;
    end
    for (int k = 0; k < 10; k++) s = (s * s) >> 31;
    return s;
  endfunction

  // apply one command to the shadow table and work out its result
  function automatic outcome_t potential_of(cmd_t c);
    outcome_t o;
    bit [63:0] r, r2, a, x, e, mag, v;
    longint acc;
    o.pot = '0;
    o.stat = STAT_OK;
    if (c.act == ACT_CLEAR) begin
      sh_count = 0;
    end else if (c.act == ACT_LOAD) begin
      if (sh_count >= MAX_PRIMS) begin
        o.stat = STAT_FULL;
      end else begin
        sh_expo[sh_count] = c.expo;
        sh_coef[sh_count] = c.coef;
        sh_pow[sh_count] = c.pow;
        sh_l[sh_count] = c.lp;
        sh_count++;
      end
    end else if (c.act == ACT_EVAL) begin
      r = {32'd0, c.rad};
      r2 = (r * r) >> 28;
      acc = 0;
      for (int i = 0; i < sh_count; i++) begin
        if (sh_l[i] == c.ql) begin
          a = {32'd0, sh_expo[i]};
          if ((r2 >> 32) != 0 && a != 0) x = EXP_CUTOFF;
          else x = (a * r2) >> 24;
          e = gauss_exp(x);
          mag = sh_coef[i][31] ? {32'd0, -sh_coef[i]} : {32'd0, sh_coef[i]};
          v = (mag * e) >> 23;
          for (int k = 0; k < sh_pow[i]; k++) begin
            v = scale_q28(v, r);
            if (v > MAG_CAP) v = MAG_CAP;
          end
          if (sh_coef[i][31]) acc = acc - longint'(v);
          else acc = acc + longint'(v);
        end
      end
      if (acc > longint'(POS_MAX)) begin
        acc = longint'(POS_MAX);
        o.stat = STAT_SAT;
      end else if (acc < -(longint'(1) << 47)) begin
        acc = -(longint'(1) << 47);
        o.stat = STAT_SAT;
      end
      o.pot = acc[47:0];
    end
    return o;
  endfunction

  task automatic add_cmd(logic [1:0] act, logic [31:0] expo, logic [31:0] coef,
                         logic [2:0] pow, logic [2:0] lp, logic [31:0] rad,
                         logic [2:0] ql, bit fixed = 0, logic [47:0] fpot = '0,
                         logic [1:0] fstat = STAT_OK);
    cmd_t c;
    c.act = act; c.expo = expo; c.coef = coef; c.pow = pow; c.lp = lp;
    c.rad = rad; c.ql = ql; c.fixed = fixed; c.fpot = fpot; c.fstat = fstat;
    cmds.insert(cmds.size(), c);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  // directed table, then random table programs with evaluations
  task automatic build_stimulus();
    int nload, neval, hot;
    logic [31:0] e, r;
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'h1000_0000, 0, 1, '0, STAT_OK);
    add_cmd(ACT_SPARE, '1, '1, 3'd7, 3'd7, '1, 3'd7, 1, '0, STAT_OK);
    add_cmd(ACT_LOAD, 0, 32'h7FFF_FFFF, 3'd4, 3'd7, 0, 0);
    add_cmd(ACT_LOAD, 0, 32'h7FFF_FFFF, 3'd4, 3'd7, 0, 0);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 3'd7, 1, POS_MAX, STAT_SAT);
    add_cmd(ACT_LOAD, 0, 32'h8000_0000, 3'd4, 3'd6, 0, 0);
    add_cmd(ACT_LOAD, 0, 32'h8000_0000, 3'd4, 3'd6, 0, 0);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 3'd6, 1, NEG_MIN, STAT_SAT);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'h1000_0000, 3'd5, 1, '0, STAT_OK);
    add_cmd(ACT_LOAD, 32'hFFFF_FFFF, 32'h0010_0000, 3'd0, 3'd1, 0, 0);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'd0, 3'd1);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 3'd1, 1, '0, STAT_OK);
    add_cmd(ACT_LOAD, 32'h0100_0000, 32'hFFF0_0000, 3'd2, 3'd2, 0, 0);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'h1000_0000, 3'd2);
    add_cmd(ACT_LOAD, 32'h0040_0000, 32'h0123_4567, 3'd7, 3'd2, 0, 0);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'h1800_0000, 3'd2);
    add_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1, '0, STAT_OK);
    add_cmd(ACT_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 3'd7, 1, '0, STAT_OK);
    while (cmds.size() < TARGET_CMDS) begin
      if ($urandom_range(0, 5) != 0) add_cmd(ACT_CLEAR, $urandom, $urandom, 0, 0, $urandom, 0);
      nload = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      hot = $urandom_range(0, 7);
      for (int i = 0; i < nload; i++) begin
        case ($urandom_range(0, 3))
          0: e = 0;
          1: e = $urandom;
          default: e = $urandom_range(0, 32'h0400_0000);
        endcase
        add_cmd(ACT_LOAD, e, $urandom, 3'($urandom_range(0, 7)),
                ($urandom_range(0, 2) != 0) ? hot[2:0] : 3'($urandom_range(0, 7)),
                $urandom, 3'($urandom_range(0, 7)));
      end
      neval = $urandom_range(1, 4);
      for (int i = 0; i < neval; i++) begin
        case ($urandom_range(0, 4))
          0: r = $urandom;
          1: r = 0;
          default: r = $urandom_range(0, 32'h3000_0000);
        endcase
        add_cmd(ACT_EVAL, $urandom, $urandom, 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), r,
                ($urandom_range(0, 3) != 0) ? hot[2:0] : 3'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 15) == 0)
        add_cmd(ACT_SPARE, $urandom, $urandom, 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)));
    end
  endtask

  // check each done strobe against the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", {16'd0, potential}, 64'd0);
      end else begin
        w = pending.pop_front();
        if (potential !== w.pot) report_mismatch("potential", {16'd0, potential}, {16'd0, w.pot});
        if (status !== w.stat) report_mismatch("status", {62'd0, status}, {62'd0, w.stat});
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int idx, burst, gap;
    bit paused;
    cmd_t c;
    outcome_t o;
    build_stimulus();
    pause_at = cmds.size() / 2;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idx = 0; paused = 0;
    burst = $urandom_range(1, 20); gap = 0;
    // drive commands in bursts; record each transfer
    while (1) begin
      @(posedge clk);
      if (start && !busy) begin
        c = cmds[idx];
        o = potential_of(c);
        if (c.act == ACT_EVAL) n_eval++;
        if (o.stat == STAT_SAT) n_sat++;
        if (o.stat == STAT_FULL) n_full++;
        if (c.fixed) begin
          o.pot = c.fpot;
          o.stat = c.fstat;
        end
        pending.insert(pending.size(), o);
        idx++;
      end else if (start) begin
        continue;
      end
      if (idx == cmds.size()) begin
        start <= 1'b0;
        break;
      end
      if (idx == pause_at && !paused) begin
        start <= 1'b0;
        paused = 1;
        while (pending.size() != 0) @(posedge clk);
        continue;
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
        continue;
      end
      c = cmds[idx];
      action <= c.act; exponent_in <= c.expo; coef_in <= c.coef; power_in <= c.pow;
      prim_l_in <= c.lp; radius <= c.rad; query_l <= c.ql;
      start <= 1'b1;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    // drain
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d commands sent, %0d evaluations, %0d saturated sums, %0d full-table loads",
             cmds.size(), n_eval, n_sat, n_full);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
